// ----- design/itp_pkg.sv -----
// Shared types, token codes and precedence helpers of the infix to postfix converter.
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_BITS  = 32;
  localparam int KIND_W      = 3;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DATA_W      = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W  = KIND_W + 1;
  localparam int PREC_W      = 5;

  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [PREC_W-1:0]     prec_t;

  // Input token kinds.
  localparam kind_t K_OPERAND = 3'd0;
  localparam kind_t K_PLUS    = 3'd1;
  localparam kind_t K_MINUS   = 3'd2;
  localparam kind_t K_TIMES   = 3'd3;
  localparam kind_t K_DIVIDE  = 3'd4;
  localparam kind_t K_LPAREN  = 3'd5;
  localparam kind_t K_RPAREN  = 3'd6;
  localparam kind_t K_END     = 3'd7;
  // Output kind of the end marker.
  localparam kind_t OUT_END   = 3'd5;

  localparam prec_t PREC_MULDIV         = 5'd10;
  localparam prec_t PREC_ADDSUB         = 5'd9;
  localparam prec_t PREC_LPAREN_IN      = 5'd20;
  localparam prec_t PREC_LPAREN_STACKED = 5'd0;

  // Source of an emitted item.
  localparam logic [1:0] EMIT_VALUE = 2'd0;
  localparam logic [1:0] EMIT_TOP   = 2'd1;
  localparam logic [1:0] EMIT_END   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] emit_sel;
    logic       last;
    logic       pop;
    logic       push;
    logic       clear;
  } itp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  cnt_one;
    logic  top_lp;
    logic  sec_lp;
    logic  pop_top;
    logic  pop_sec;
    logic  sec_ok;
    logic  out_free;
  } itp_status_t;

  function automatic prec_t stacked_prec(kind_t k);
    prec_t p;
    if (k == K_TIMES || k == K_DIVIDE) p = PREC_MULDIV;
    else if (k == K_PLUS || k == K_MINUS) p = PREC_ADDSUB;
    else p = PREC_LPAREN_STACKED;
    return p;
  endfunction

  function automatic prec_t incoming_prec(kind_t k);
    prec_t p;
    if (k == K_TIMES || k == K_DIVIDE) p = PREC_MULDIV;
    else if (k == K_PLUS || k == K_MINUS) p = PREC_ADDSUB;
    else p = PREC_LPAREN_IN;
    return p;
  endfunction

endpackage

// ----- design/infix_to_postfix_converter_unit.sv -----
// Top level of the streaming infix to postfix converter.
// Usage: one infix token enters per item on the s_axis channel (tuser = token
// kind, tdata = operand value). Postfix tokens leave on the m_axis channel
// (tdata = operand value or zero, tuser = kind and error flag, tlast on the
// final item released by each input item). Operators and left parentheses
// wait on a 16-entry stack that lives in a small memory.
// Timing: an input item is taken while the converter is idle and handled in
// the cycle after; a new item is taken only once the last one is finished.
// The first stack pop of an item follows the take directly; each further pop
// waits until the memory read of the entry below the top has settled after
// the count changes. The first result passes through the token registers
// and then the output register before it leaves.
// Reset empties the stack and clears the error flag; no clearing pass is
// needed. When the receiver stalls, the finished item waits in the output
// register and the converter holds until it is taken.
module infix_to_postfix_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [itp_pkg::DATA_W-1:0]    s_axis_tdata,  // [31:0] operand_value
  input  logic [itp_pkg::KIND_W-1:0]    s_axis_tuser,  // [2:0] func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [itp_pkg::DATA_W-1:0]    m_axis_tdata,  // [31:0] out_value
  output logic [itp_pkg::OUT_USER_W-1:0] m_axis_tuser, // [2:0] out_kind, [3] error
  output logic                          m_axis_tlast
);
  import itp_pkg::*;

  itp_cmd_t    cmd;
  itp_status_t status;
  kind_t       m_kind;
  value_t      m_value;
  logic        m_error;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .s_func_i   (s_axis_tuser),
    .s_value_i  (s_axis_tdata[VALUE_BITS-1:0]),
    .m_tready_i (m_axis_tready),
    .status_o   (status),
    .m_valid_o  (m_axis_tvalid),
    .m_kind_o   (m_kind),
    .m_value_o  (m_value),
    .m_last_o   (m_axis_tlast),
    .m_error_o  (m_error)
  );

  assign m_axis_tdata = DATA_W'(m_value);
  assign m_axis_tuser = {m_error, m_kind};

endmodule

// ----- design/itp_datapath.sv -----
// Operator stack, token registers and output register of the converter.
module itp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itp_pkg::itp_cmd_t   cmd_i,
  input  itp_pkg::kind_t      s_func_i,
  input  itp_pkg::value_t     s_value_i,
  input  logic                m_tready_i,
  output itp_pkg::itp_status_t status_o,
  output logic                m_valid_o,
  output itp_pkg::kind_t      m_kind_o,
  output itp_pkg::value_t     m_value_o,
  output logic                m_last_o,
  output logic                m_error_o
);
  import itp_pkg::*;

  kind_t  stack_mem [STACK_DEPTH];
  kind_t  sec_q;
  kind_t  top_q, top_d;
  kind_t  kind_q;
  value_t value_q;
  cnt_t   count_q, count_d;
  cnt_t   lp_cnt_q, lp_cnt_d;
  cnt_t   rd_cnt;
  logic   err_q, err_d;
  logic   sec_ok_q;
  logic   full;
  logic   wr_en;
  logic   in_is_op;
  logic   in_pops;
  logic   pred_err;

  logic   out_valid_q;
  kind_t  out_kind_q;
  value_t out_value_q;
  logic   out_last_q;
  logic   out_err_q;
  logic   out_free;

  assign full     = (count_q == cnt_t'(STACK_DEPTH));
  assign wr_en    = cmd_i.push && !full;
  assign rd_cnt   = count_q - cnt_t'(2);
  assign out_free = !out_valid_q || m_tready_i;

  // The error of a whole step is known before its first item leaves.
  always_comb begin
    in_is_op = (s_func_i == K_PLUS) || (s_func_i == K_MINUS) ||
               (s_func_i == K_TIMES) || (s_func_i == K_DIVIDE);
    in_pops  = (count_q != '0) && (top_q != K_LPAREN) &&
               (stacked_prec(top_q) >= incoming_prec(s_func_i));
    pred_err = (in_is_op && full && !in_pops) ||
               ((s_func_i == K_LPAREN) && full) ||
               ((s_func_i == K_RPAREN) && (lp_cnt_q == '0)) ||
               ((s_func_i == K_END) && (lp_cnt_q != '0));
  end

  always_comb begin
    count_d  = count_q;
    lp_cnt_d = lp_cnt_q;
    top_d    = top_q;
    err_d    = err_q;
    if (cmd_i.load) begin
      err_d = err_q | pred_err;
    end
    if (cmd_i.pop) begin
      count_d = count_q - cnt_t'(1);
      top_d   = sec_q;
      if (top_q == K_LPAREN) lp_cnt_d = lp_cnt_q - cnt_t'(1);
    end
    if (wr_en) begin
      count_d = count_q + cnt_t'(1);
      top_d   = kind_q;
      if (kind_q == K_LPAREN) lp_cnt_d = lp_cnt_q + cnt_t'(1);
    end
    if (cmd_i.clear) begin
      count_d  = '0;
      lp_cnt_d = '0;
      err_d    = 1'b0;
    end
  end

  // The entry below the top is read every cycle; it is good once the count has held.
  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[count_q[IDX_W-1:0]] <= kind_q;
    sec_q <= stack_mem[rd_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      lp_cnt_q    <= '0;
      err_q       <= 1'b0;
      sec_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      lp_cnt_q <= lp_cnt_d;
      err_q    <= err_d;
      sec_ok_q <= (count_d == count_q);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.load) begin
      kind_q  <= s_func_i;
      value_q <= s_value_i;
    end
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.last;
      out_err_q  <= err_q;
      case (cmd_i.emit_sel)
        EMIT_VALUE: begin
          out_kind_q  <= K_OPERAND;
          out_value_q <= value_q;
        end
        EMIT_TOP: begin
          out_kind_q  <= top_q;
          out_value_q <= '0;
        end
        default: begin
          out_kind_q  <= OUT_END;
          out_value_q <= '0;
        end
      endcase
    end
  end

  always_comb begin
    status_o.kind     = kind_q;
    status_o.cnt_zero = (count_q == '0);
    status_o.cnt_one  = (count_q == cnt_t'(1));
    status_o.top_lp   = (top_q == K_LPAREN);
    status_o.sec_lp   = (sec_q == K_LPAREN);
    status_o.pop_top  = (count_q != '0) && (top_q != K_LPAREN) &&
                        (stacked_prec(top_q) >= incoming_prec(kind_q));
    status_o.pop_sec  = (count_q > cnt_t'(1)) && (sec_q != K_LPAREN) &&
                        (stacked_prec(sec_q) >= incoming_prec(kind_q));
    status_o.sec_ok   = sec_ok_q;
    status_o.out_free = out_free;
  end

  assign m_valid_o = out_valid_q;
  assign m_kind_o  = out_kind_q;
  assign m_value_o = out_value_q;
  assign m_last_o  = out_last_q;
  assign m_error_o = out_err_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(STACK_DEPTH)) else $error("stack count out of range");
  a_lp_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lp_cnt_q <= count_q) else $error("more left parentheses than entries");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0) else $error("pop from an empty stack");
`endif

endmodule

// ----- design/itp_ctrl.sv -----
// Sequencer that steps one token through the shunting-yard decisions.
module itp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  itp_pkg::itp_status_t status_i,
  output itp_pkg::itp_cmd_t    cmd_o
);
  import itp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: begin
        case (status_i.kind)
          K_OPERAND: begin
            if (status_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = EMIT_VALUE;
              cmd_o.last     = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          K_PLUS, K_MINUS, K_TIMES, K_DIVIDE: begin
            if (status_i.pop_top) begin
              if (status_i.sec_ok && status_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = EMIT_TOP;
                cmd_o.last     = !status_i.pop_sec;
                cmd_o.pop      = 1'b1;
              end
            end else begin
              cmd_o.push = 1'b1;
              state_d    = ST_IDLE;
            end
          end
          K_LPAREN: begin
            cmd_o.push = 1'b1;
            state_d    = ST_IDLE;
          end
          K_RPAREN: begin
            if (status_i.cnt_zero) begin
              state_d = ST_IDLE;
            end else if (status_i.sec_ok) begin
              if (status_i.top_lp) begin
                cmd_o.pop = 1'b1;
                state_d   = ST_IDLE;
              end else if (status_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = EMIT_TOP;
                cmd_o.last     = status_i.cnt_one || status_i.sec_lp;
                cmd_o.pop      = 1'b1;
              end
            end
          end
          default: begin
            // End of expression: flush, then the end marker.
            if (status_i.cnt_zero) begin
              if (status_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = EMIT_END;
                cmd_o.last     = 1'b1;
                cmd_o.clear    = 1'b1;
                state_d        = ST_IDLE;
              end
            end else if (status_i.sec_ok) begin
              if (status_i.top_lp) begin
                cmd_o.pop = 1'b1;
              end else if (status_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = EMIT_TOP;
                cmd_o.pop      = 1'b1;
              end
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> state_q == ST_RUN) else $error("item emitted outside a step");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free) else $error("output register overwritten");
  a_pop_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> status_i.sec_ok) else $error("pop before stack read settled");
`endif

endmodule
